>>> sv/spg_pkg.sv
// Shared types and constants of the spectrum plot pixel generator.
`timescale 1ns / 1ps
`default_nettype none
package spg_pkg;

    localparam int MAG_W     = 32;
    localparam int COLOR_W   = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam int MUL_OP_W  = 33;
    localparam int MUL_PROD_W = 2 * MUL_OP_W;

    typedef logic signed [MUL_OP_W-1:0]   mul_op_t;
    typedef logic signed [MUL_PROD_W-1:0] mul_prod_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_ZOOM_RECIP = 4'd0,
        CFG_X_PAN        = 4'd1,
        CFG_Y_ZOOM       = 4'd2,
        CFG_Y_PAN        = 4'd3,
        CFG_BG_COLOR     = 4'd4,
        CFG_GRID_COLOR   = 4'd5,
        CFG_TRACE1_COLOR = 4'd6,
        CFG_TRACE2_COLOR = 4'd7
    } cfg_idx_e;

    localparam logic [15:0] RST_X_ZOOM_RECIP = 16'd256;
    localparam logic [15:0] RST_Y_ZOOM       = 16'd256;
    localparam logic [15:0] RST_BG_COLOR     = 16'd0;
    localparam logic [15:0] RST_GRID_COLOR   = 16'd31727;
    localparam logic [15:0] RST_TRACE1_COLOR = 16'd2047;
    localparam logic [15:0] RST_TRACE2_COLOR = 16'd65504;

    localparam longint LOG_BIAS      = 64'sd1310720;
    localparam longint OCTAVE_DB_Q16 = 64'sd394566;
    localparam longint ROUND_HALF    = 64'sd8388608;
    localparam int     LEVEL_SHIFT   = 24;
    localparam int     LEVEL_FLOOR   = -15360;
    localparam int     LEVEL_HALF    = 7680;
    localparam int     LEVEL_SPAN    = 15360;
    localparam longint ROW_DEN       = 64'sd3932160;
    localparam int     ROW_DEN_SHIFT = 18;
    localparam int     DIV15_MAGIC   = 34953;
    localparam int     DIV15_SHIFT   = 19;

endpackage
`default_nettype wire

>>> sv/spg_if.sv
// Channel interfaces: input items, result items and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface spg_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic        channel;
    logic [7:0]  bin_index;
    logic [31:0] magnitude;
    logic [7:0]  row;
    logic [8:0]  column;
    modport source (output valid, kind, channel, bin_index, magnitude, row, column,
                    input ready);
    modport sink   (input valid, kind, channel, bin_index, magnitude, row, column,
                    output ready);
endinterface

interface spg_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_color;
    modport source (output valid, pixel_color, input ready);
    modport sink   (input valid, pixel_color, output ready);
endinterface

interface spg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [spg_pkg::CFG_IDX_W-1:0]  index;
    logic [spg_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/spg_mul.sv
// Shared registered signed multiplier.
`timescale 1ns / 1ps
`default_nettype none
module spg_mul (
    input  wire logic              clk,
    input  wire spg_pkg::mul_op_t  op_a,
    input  wire spg_pkg::mul_op_t  op_b,
    output spg_pkg::mul_prod_t     prod
);
    import spg_pkg::*;

    always_ff @(posedge clk)
    begin
        prod <= MUL_PROD_W'(op_a) * MUL_PROD_W'(op_b);
    end

endmodule
`default_nettype wire

>>> sv/spg_store.sv
// Two-channel magnitude memory with a clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module spg_store #(
    parameter int AW = 9
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [AW-1:0]               wr_addr,
    input  wire logic [spg_pkg::MAG_W-1:0]   wr_data,
    input  wire logic [AW-1:0]               rd_addr,
    output logic      [spg_pkg::MAG_W-1:0]   rd_data,
    output logic                             busy
);
    import spg_pkg::*;

    localparam int DEPTH = 2 ** AW;

    logic [MAG_W-1:0] mem [DEPTH];
    logic [AW-1:0]    clr_addr_reg;
    logic             busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else if (busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    assign busy = busy_reg;

endmodule
`default_nettype wire

>>> sv/spectrum_plot_pixel_generator.sv
// Top level: register file, query sequencer and pixel colour selection.
`timescale 1ns / 1ps
`default_nettype none
// A load item writes one magnitude if its bin index is below BINS. A pixel query
// runs through one shared multiplier under a sequencer: it maps the column and
// the next column to bins, then each of the four magnitudes passes through a
// memory read, one-bit normalization, log2 squaring and dB, pan, zoom and clamp
// arithmetic; a last step paints the pixel, and it waits while the previous
// result is still unaccepted. After reset the block clears its
// 2^(clog2(BINS)+1)-word memory and accepts no item meanwhile; register writes
// are taken at any time.
module spectrum_plot_pixel_generator #(
    parameter int PLOT_WIDTH  = 320,
    parameter int PLOT_HEIGHT = 200,
    parameter int BINS        = 256
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    spg_item_if.sink     item,
    spg_result_if.source result,
    spg_cfg_if.sink      cfg
);
    import spg_pkg::*;

    localparam int FW = $clog2(PLOT_WIDTH);
    localparam int RW = $clog2(PLOT_HEIGHT);
    localparam int BW = $clog2(BINS);
    localparam int AW = BW + 1;
    localparam int QW = $clog2(15 * PLOT_HEIGHT);
    localparam longint RECIP_W  = ((64'sd1 <<< 32) + PLOT_WIDTH - 1) / PLOT_WIDTH;
    localparam longint HALF_NUM = longint'(PLOT_HEIGHT / 2) * ROW_DEN;
    localparam logic signed [33:0] XS_BIAS = 34'(PLOT_WIDTH * 256);

    typedef enum logic [4:0] {
        S_IDLE, S_COL_MUL, S_COL_FIX, S_BIN_MUL, S_BIN_SCALE, S_BIN_FIX,
        S_RD, S_RD_W, S_NORM, S_SQ, S_SQ_W, S_LV_MUL, S_LV_FIX,
        S_RW_MUL, S_RW_ZOOM, S_RW_FIX, S_RW_DIV, S_RW_DONE, S_PAINT
    } state_t;

    state_t               state_reg;
    logic [7:0]           row_reg;
    logic [8:0]           col_reg;
    logic                 cidx_reg;
    logic [1:0]           k_reg;
    logic [FW-1:0]        f_reg;
    logic [BW-1:0]        bin_reg [2];
    logic [31:0]          x_reg;
    logic [4:0]           e_reg;
    logic [15:0]          frac_reg;
    logic [3:0]           i_reg;
    logic signed [15:0]   lv_reg;
    logic [QW-1:0]        q_reg;
    logic [RW-1:0]        trow_reg [4];
    logic                 out_valid_reg;
    logic [COLOR_W-1:0]   out_color_reg;

    logic [15:0]          x_zoom_recip_reg;
    logic signed [10:0]   x_pan_reg;
    logic [15:0]          y_zoom_reg;
    logic signed [9:0]    y_pan_reg;
    logic [15:0]          bg_color_reg;
    logic [15:0]          grid_color_reg;
    logic [15:0]          trace1_color_reg;
    logic [15:0]          trace2_color_reg;

    mul_op_t              mul_a;
    mul_op_t              mul_b;
    mul_prod_t            mul_p;

    logic                 clr_busy;
    logic                 item_acc;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic [MAG_W-1:0]     rd_data;

    logic [9:0]           px;
    logic signed [33:0]   xs;
    logic signed [33:0]   xs_sh;
    logic [FW-1:0]        f_next;
    logic [BW-1:0]        bin_sel;
    logic signed [MUL_PROD_W-1:0] lv_full;
    logic signed [15:0]   lv_next;
    logic signed [47:0]   num;
    logic signed [47:0]   q_full;
    logic [QW-1:0]        q_next;
    logic [32:0]          sq_y;
    logic [MAG_W-1:0]     mag_next;
    logic [10:0]          row_e;
    logic [10:0]          col_e;
    logic                 grid_hit;
    logic [COLOR_W-1:0]   color_next;

    function automatic logic in_span(input logic [RW-1:0] r, input logic [RW-1:0] a,
                                     input logic [RW-1:0] b);
        logic [RW-1:0] lo;
        logic [RW-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (r >= lo) && (r <= hi);
    endfunction

    spg_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    spg_store #(.AW(AW)) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item.magnitude),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .busy    (clr_busy)
    );

    assign item.ready   = (state_reg == S_IDLE) && !clr_busy;
    assign item_acc     = item.valid && item.ready;
    assign wr_en        = item_acc && !item.kind && ({24'd0, item.bin_index} < 32'(BINS));
    assign wr_addr      = {item.channel, BW'(item.bin_index)};
    assign rd_addr      = {k_reg[1], bin_reg[k_reg[0]]};
    assign cfg.ready    = 1'b1;
    assign result.valid       = out_valid_reg;
    assign result.pixel_color = out_color_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        px    = {1'b0, col_reg} + 10'(cidx_reg);
        case (state_reg)
            S_COL_MUL:
            begin
                mul_a = MUL_OP_W'($signed({1'b0, px, 1'b0}) - 12'sd0 - 12'(PLOT_WIDTH));
                mul_b = MUL_OP_W'({1'b0, x_zoom_recip_reg});
            end
            S_BIN_MUL:
            begin
                mul_a = MUL_OP_W'({1'b0, f_reg});
                mul_b = MUL_OP_W'(BINS);
            end
            S_BIN_SCALE:
            begin
                mul_a = mul_p[MUL_OP_W-1:0];
                mul_b = MUL_OP_W'(RECIP_W);
            end
            S_SQ:
            begin
                mul_a = {1'b0, x_reg};
                mul_b = {1'b0, x_reg};
            end
            S_LV_MUL:
            begin
                mul_a = MUL_OP_W'($signed({1'b0, e_reg, frac_reg})) - MUL_OP_W'(LOG_BIAS);
                mul_b = MUL_OP_W'(OCTAVE_DB_Q16);
            end
            S_RW_MUL:
            begin
                mul_a = MUL_OP_W'(lv_reg) + MUL_OP_W'(LEVEL_HALF);
                mul_b = MUL_OP_W'(PLOT_HEIGHT);
            end
            S_RW_ZOOM:
            begin
                mul_a = mul_p[MUL_OP_W-1:0] + MUL_OP_W'(y_pan_reg) * MUL_OP_W'(LEVEL_SPAN);
                mul_b = MUL_OP_W'({1'b0, y_zoom_reg});
            end
            S_RW_DIV:
            begin
                mul_a = MUL_OP_W'({1'b0, q_reg});
                mul_b = MUL_OP_W'(DIV15_MAGIC);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        xs    = $signed(mul_p[33:0]) + XS_BIAS + (34'(x_pan_reg) <<< 9);
        xs_sh = xs >>> 9;
        if (xs < 0)
        begin
            f_next = '0;
        end
        else if (xs_sh >= 34'(PLOT_WIDTH))
        begin
            f_next = FW'(PLOT_WIDTH - 1);
        end
        else
        begin
            f_next = xs_sh[FW-1:0];
        end

        if (mul_p[64:32] >= 33'(BINS))
        begin
            bin_sel = BW'(BINS - 1);
        end
        else
        begin
            bin_sel = mul_p[32 +: BW];
        end

        lv_full = (mul_p + MUL_PROD_W'(ROUND_HALF)) >>> LEVEL_SHIFT;
        if (lv_full < MUL_PROD_W'(LEVEL_FLOOR))
        begin
            lv_next = 16'(LEVEL_FLOOR);
        end
        else
        begin
            lv_next = lv_full[15:0];
        end

        num    = 48'(HALF_NUM) - $signed(mul_p[47:0]);
        q_full = num >>> ROW_DEN_SHIFT;
        if (q_full < 0)
        begin
            q_next = '0;
        end
        else if (q_full > 48'(15 * PLOT_HEIGHT - 1))
        begin
            q_next = QW'(15 * PLOT_HEIGHT - 1);
        end
        else
        begin
            q_next = q_full[QW-1:0];
        end

        sq_y = mul_p[63:31];

        if (bin_reg[k_reg[0]] == '0 || rd_data == '0)
        begin
            mag_next = MAG_W'(1);
        end
        else
        begin
            mag_next = rd_data;
        end

        row_e = {3'd0, row_reg};
        col_e = {2'd0, col_reg};
        grid_hit = (row_e == 11'(PLOT_HEIGHT - 1)) || (col_e == 11'd0)
            || (col_e == 11'(PLOT_WIDTH / 4)) || (col_e == 11'(PLOT_WIDTH / 2))
            || (col_e == 11'(3 * PLOT_WIDTH / 4))
            || (row_e == 11'(PLOT_HEIGHT / 4)) || (row_e == 11'(PLOT_HEIGHT / 2))
            || (row_e == 11'(3 * PLOT_HEIGHT / 4));
        color_next = bg_color_reg;
        if (grid_hit)
        begin
            color_next = grid_color_reg;
        end
        if (row_e <= 11'(PLOT_HEIGHT - 1)
            && in_span(RW'(row_reg), trow_reg[0], trow_reg[1]))
        begin
            color_next = trace1_color_reg;
        end
        if (row_e <= 11'(PLOT_HEIGHT - 1)
            && in_span(RW'(row_reg), trow_reg[2], trow_reg[3]))
        begin
            color_next = trace2_color_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            x_zoom_recip_reg <= RST_X_ZOOM_RECIP;
            x_pan_reg        <= '0;
            y_zoom_reg       <= RST_Y_ZOOM;
            y_pan_reg        <= '0;
            bg_color_reg     <= RST_BG_COLOR;
            grid_color_reg   <= RST_GRID_COLOR;
            trace1_color_reg <= RST_TRACE1_COLOR;
            trace2_color_reg <= RST_TRACE2_COLOR;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg_idx_e'(cfg.index))
                    CFG_X_ZOOM_RECIP: x_zoom_recip_reg <= cfg.data;
                    CFG_X_PAN:        x_pan_reg        <= cfg.data[10:0];
                    CFG_Y_ZOOM:       y_zoom_reg       <= cfg.data;
                    CFG_Y_PAN:        y_pan_reg        <= cfg.data[9:0];
                    CFG_BG_COLOR:     bg_color_reg     <= cfg.data;
                    CFG_GRID_COLOR:   grid_color_reg   <= cfg.data;
                    CFG_TRACE1_COLOR: trace1_color_reg <= cfg.data;
                    CFG_TRACE2_COLOR: trace2_color_reg <= cfg.data;
                    default: ;
                endcase
            end

            if (result.ready && (state_reg != S_PAINT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (item_acc && item.kind)
                    begin
                        row_reg   <= item.row;
                        col_reg   <= item.column;
                        cidx_reg  <= 1'b0;
                        state_reg <= S_COL_MUL;
                    end
                end
                S_COL_MUL:   state_reg <= S_COL_FIX;
                S_COL_FIX:
                begin
                    f_reg     <= f_next;
                    state_reg <= S_BIN_MUL;
                end
                S_BIN_MUL:   state_reg <= S_BIN_SCALE;
                S_BIN_SCALE: state_reg <= S_BIN_FIX;
                S_BIN_FIX:
                begin
                    bin_reg[cidx_reg] <= bin_sel;
                    if (!cidx_reg)
                    begin
                        cidx_reg  <= 1'b1;
                        state_reg <= S_COL_MUL;
                    end
                    else
                    begin
                        k_reg     <= 2'd0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:        state_reg <= S_RD_W;
                S_RD_W:
                begin
                    x_reg     <= mag_next;
                    e_reg     <= 5'd31;
                    state_reg <= S_NORM;
                end
                S_NORM:
                begin
                    if (x_reg[31])
                    begin
                        i_reg     <= 4'd15;
                        state_reg <= S_SQ;
                    end
                    else
                    begin
                        x_reg <= {x_reg[30:0], 1'b0};
                        e_reg <= e_reg - 1'b1;
                    end
                end
                S_SQ:        state_reg <= S_SQ_W;
                S_SQ_W:
                begin
                    frac_reg[i_reg] <= sq_y[32];
                    x_reg <= sq_y[32] ? sq_y[32:1] : sq_y[31:0];
                    if (i_reg == 4'd0)
                    begin
                        state_reg <= S_LV_MUL;
                    end
                    else
                    begin
                        i_reg     <= i_reg - 1'b1;
                        state_reg <= S_SQ;
                    end
                end
                S_LV_MUL:    state_reg <= S_LV_FIX;
                S_LV_FIX:
                begin
                    lv_reg    <= lv_next;
                    state_reg <= S_RW_MUL;
                end
                S_RW_MUL:    state_reg <= S_RW_ZOOM;
                S_RW_ZOOM:   state_reg <= S_RW_FIX;
                S_RW_FIX:
                begin
                    q_reg     <= q_next;
                    state_reg <= S_RW_DIV;
                end
                S_RW_DIV:    state_reg <= S_RW_DONE;
                S_RW_DONE:
                begin
                    trow_reg[k_reg] <= mul_p[DIV15_SHIFT +: RW];
                    k_reg <= k_reg + 1'b1;
                    state_reg <= (k_reg == 2'd3) ? S_PAINT : S_RD;
                end
                S_PAINT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_color_reg <= color_next;
                        state_reg     <= S_IDLE;
                    end
                end
                default:     state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_not_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !clr_busy)
        else $error("item taken during memory clear");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && !item.kind && !result.valid) |=> !result.valid)
        else $error("load produced a result");

    a_rows_in_plot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAINT) |-> (trow_reg[0] <= RW'(PLOT_HEIGHT - 1)
            && trow_reg[1] <= RW'(PLOT_HEIGHT - 1) && trow_reg[2] <= RW'(PLOT_HEIGHT - 1)
            && trow_reg[3] <= RW'(PLOT_HEIGHT - 1)))
        else $error("trace row outside plot");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.kind) |=> !item.ready)
        else $error("ready during query");
`endif

endmodule
`default_nettype wire

>>> tb/spectrum_plot_pixel_generator_tb.sv
// Self-checking testbench for the spectrum plot pixel generator.
`timescale 1ns / 1ps
`default_nettype none
module spectrum_plot_pixel_generator_tb;
    import spg_pkg::*;

    localparam int PW = 320;
    localparam int PH = 200;
    localparam int NB = 256;

    typedef struct packed {
        logic        kind;
        logic        channel;
        logic [7:0]  bin_index;
        logic [31:0] magnitude;
        logic [7:0]  row;
        logic [8:0]  column;
    } plot_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    spg_item_if   item_ch ();
    spg_result_if result_ch ();
    spg_cfg_if    cfg_ch ();

    spectrum_plot_pixel_generator u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    always #6 clk = ~clk;

    logic [31:0] mag_store [2][NB];
    logic [15:0] x_zoom_recip_m, y_zoom_m;
    logic signed [10:0] x_pan_m;
    logic signed [9:0]  y_pan_m;
    logic [15:0] bg_color_m, grid_color_m, trace1_color_m, trace2_color_m;

    plot_item_t  pending_items [$];
    logic [15:0] expected_colors [$];
    int          error_count = 0;
    int          send_idle_pct = 12;
    int          recv_idle_pct = 46;
    int          hold_off_cycles = 0;
    logic        item_taken = 1'b0;

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint log2_fixed(logic [31:0] m);
        int          e;
        logic [63:0] x;
        longint      f;
        f = 0;
        if (m == 0)
            m = 1;
        e = 31;
        while (m[e] == 1'b0)
            e--;
        x = 64'(m) << (31 - e);
        for (int i = 15; i >= 0; i--)
        begin
            x = (x * x) >> 31;
            if (x >= 64'h1_0000_0000)
            begin
                f = f | (longint'(1) << i);
                x = x >> 1;
            end
        end
        return (longint'(e) << 16) | f;
    endfunction

    function automatic longint row_of_magnitude(logic [31:0] m);
        longint lv, num, r;
        lv = floor_div((log2_fixed(m) - 20 * 65536) * 394566 + (longint'(1) << 23),
                       longint'(1) << 24);
        if (lv < -15360)
            lv = -15360;
        num = longint'(PH / 2) * 3932160
            - ((lv + 7680) * PH + longint'(y_pan_m) * 15360) * longint'(y_zoom_m);
        r = floor_div(num, 3932160);
        if (r < 0)
            r = 0;
        if (r > PH - 1)
            r = PH - 1;
        return r;
    endfunction

    function automatic int bin_of_column(longint px);
        longint xs, f, b;
        xs = (2 * px - PW) * longint'(x_zoom_recip_m) + longint'(PW) * 256
           + longint'(x_pan_m) * 512;
        f = (xs < 0) ? 0 : (xs >>> 9);
        if (f >= PW)
            f = PW - 1;
        b = f * NB / PW;
        if (b >= NB)
            b = NB - 1;
        return int'(b);
    endfunction

    function automatic logic [31:0] stored_mag(int ch, int b);
        return (b == 0) ? 32'd0 : mag_store[ch][b];
    endfunction

    function automatic logic row_between(longint r, longint a, longint b);
        return (r >= ((a < b) ? a : b)) && (r <= ((a < b) ? b : a));
    endfunction

    task automatic predict_pixel(plot_item_t it);
        longint r, c;
        int     b0, b1;
        logic [15:0] color;
        if (it.kind == 1'b0)
        begin
            mag_store[it.channel][it.bin_index] = it.magnitude;
            return;
        end
        r = it.row;
        c = it.column;
        b0 = bin_of_column(c);
        b1 = bin_of_column(c + 1);
        color = bg_color_m;
        if (r == PH - 1 || c == 0 || c == PW / 4 || c == PW / 2 || c == 3 * PW / 4
            || r == PH / 4 || r == PH / 2 || r == 3 * PH / 4)
            color = grid_color_m;
        if (row_between(r, row_of_magnitude(stored_mag(0, b0)),
                        row_of_magnitude(stored_mag(0, b1))))
            color = trace1_color_m;
        if (row_between(r, row_of_magnitude(stored_mag(1, b0)),
                        row_of_magnitude(stored_mag(1, b1))))
            color = trace2_color_m;
        expected_colors.push_back(color);
    endtask

    task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            CFG_X_ZOOM_RECIP: x_zoom_recip_m = value;
            CFG_X_PAN:        x_pan_m = value[10:0];
            CFG_Y_ZOOM:       y_zoom_m = value;
            CFG_Y_PAN:        y_pan_m = value[9:0];
            CFG_BG_COLOR:     bg_color_m = value;
            CFG_GRID_COLOR:   grid_color_m = value;
            CFG_TRACE1_COLOR: trace1_color_m = value;
            CFG_TRACE2_COLOR: trace2_color_m = value;
            default:          ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || item_ch.valid || expected_colors.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic plot_item_t load_item(logic ch, logic [7:0] b, logic [31:0] m);
        plot_item_t it;
        it = '0;
        it.kind = 1'b0;
        it.channel = ch;
        it.bin_index = b;
        it.magnitude = m;
        it.row = 8'($urandom);
        it.column = 9'($urandom);
        return it;
    endfunction

    function automatic plot_item_t query_item(logic [7:0] r, logic [8:0] c);
        plot_item_t it;
        it = '0;
        it.kind = 1'b1;
        it.channel = 1'($urandom);
        it.bin_index = 8'($urandom);
        it.magnitude = $urandom;
        it.row = r;
        it.column = c;
        return it;
    endfunction

    function automatic logic [31:0] random_mag();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 1100);
            1: return $urandom >> $urandom_range(0, 31);
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(1 << 16, 1 << 26);
        endcase
    endfunction

    // One phase: a random mix of loads and queries, with stray queries that may fall off the plot.
    task automatic queue_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 35)
                pending_items.push_back(load_item(1'($urandom), 8'($urandom), random_mag()));
            else if ($urandom_range(0, 9) == 0)
                pending_items.push_back(query_item(8'($urandom), 9'($urandom)));
            else
                pending_items.push_back(query_item($urandom_range(0, PH - 1),
                                                   $urandom_range(0, PW - 1)));
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            item_ch.valid <= 1'b0;
        else if (!item_ch.valid || item_taken)
        begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                plot_item_t it;
                it = pending_items.pop_front();
                item_ch.valid     <= 1'b1;
                item_ch.kind      <= it.kind;
                item_ch.channel   <= it.channel;
                item_ch.bin_index <= it.bin_index;
                item_ch.magnitude <= it.magnitude;
                item_ch.row       <= it.row;
                item_ch.column    <= it.column;
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        item_taken <= rst_n && item_ch.valid && item_ch.ready;
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            plot_item_t it;
            it.kind      = item_ch.kind;
            it.channel   = item_ch.channel;
            it.bin_index = item_ch.bin_index;
            it.magnitude = item_ch.magnitude;
            it.row       = item_ch.row;
            it.column    = item_ch.column;
            predict_pixel(it);
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_colors.size() == 0)
            begin
                $error("pixel_color: unexpected transaction, actual %h", result_ch.pixel_color);
                error_count++;
            end
            else
            begin
                logic [15:0] want;
                want = expected_colors.pop_front();
                if (result_ch.pixel_color !== want)
                begin
                    $error("pixel_color: expected %h actual %h", want, result_ch.pixel_color);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.kind = 1'b0;
        item_ch.channel = 1'b0;
        item_ch.bin_index = '0;
        item_ch.magnitude = '0;
        item_ch.row = '0;
        item_ch.column = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_X_ZOOM_RECIP;
        cfg_ch.data = '0;
        x_zoom_recip_m = RST_X_ZOOM_RECIP;
        y_zoom_m = RST_Y_ZOOM;
        x_pan_m = '0;
        y_pan_m = '0;
        bg_color_m = RST_BG_COLOR;
        grid_color_m = RST_GRID_COLOR;
        trace1_color_m = RST_TRACE1_COLOR;
        trace2_color_m = RST_TRACE2_COLOR;
        for (int c = 0; c < 2; c++)
            for (int b = 0; b < NB; b++)
                mag_store[c][b] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extreme magnitudes, bin zero, grid lines, off-plot queries
        pending_items.push_back(query_item(8'd0, 9'd0));
        pending_items.push_back(load_item(1'b0, 8'd0, 32'hFFFF_FFFF));
        pending_items.push_back(load_item(1'b1, 8'd1, 32'hFFFF_FFFF));
        pending_items.push_back(load_item(1'b0, 8'd128, 32'd1 << 20));
        pending_items.push_back(load_item(1'b1, 8'd255, 32'd1));
        pending_items.push_back(load_item(1'b0, 8'd255, 32'd0));
        pending_items.push_back(load_item(1'b1, 8'd129, 32'd1000));
        pending_items.push_back(load_item(1'b0, 8'd129, 32'd1100));
        pending_items.push_back(query_item(8'd199, 9'd1));
        pending_items.push_back(query_item(8'd50, 9'd80));
        pending_items.push_back(query_item(8'd100, 9'd160));
        pending_items.push_back(query_item(8'd150, 9'd240));
        pending_items.push_back(query_item(8'd255, 9'd511));
        pending_items.push_back(query_item(8'd0, 9'd319));
        pending_items.push_back(query_item(8'd10, 9'd159));
        pending_items.push_back(query_item(8'd73, 9'd161));
        pending_items.push_back(query_item(8'd200, 9'd320));
        wait_drained();

        write_reg(CFG_X_ZOOM_RECIP, 16'd0);
        write_reg(CFG_Y_ZOOM, 16'd0);
        pending_items.push_back(query_item(8'd100, 9'd0));
        pending_items.push_back(query_item(8'd99, 9'd300));
        wait_drained();
        write_reg(CFG_X_ZOOM_RECIP, 16'hFFFF);
        write_reg(CFG_X_PAN, 16'h0580);
        write_reg(CFG_Y_ZOOM, 16'hFFFF);
        write_reg(CFG_Y_PAN, 16'h0270);
        write_reg(CFG_BG_COLOR, 16'hFFFF);
        write_reg(CFG_GRID_COLOR, 16'h0000);
        write_reg(CFG_TRACE1_COLOR, 16'hAAAA);
        write_reg(CFG_TRACE2_COLOR, 16'h5555);
        write_reg(cfg_idx_e'(4'd12), 16'h1234);
        pending_items.push_back(query_item(8'd0, 9'd0));
        pending_items.push_back(query_item(8'd199, 9'd319));
        wait_drained();

        write_reg(CFG_X_ZOOM_RECIP, 16'd1);
        write_reg(CFG_X_PAN, 16'd640);
        write_reg(CFG_Y_ZOOM, 16'd1);
        write_reg(CFG_Y_PAN, 16'd400);
        queue_phase(120);
        wait_drained();

        // zoom and pan back to defaults, then long receiver hold-off to fill the block
        write_reg(CFG_X_ZOOM_RECIP, RST_X_ZOOM_RECIP);
        write_reg(CFG_X_PAN, 16'd0);
        write_reg(CFG_Y_ZOOM, RST_Y_ZOOM);
        write_reg(CFG_Y_PAN, 16'd0);
        write_reg(CFG_BG_COLOR, 16'h0001);
        write_reg(CFG_GRID_COLOR, 16'h8000);
        write_reg(CFG_TRACE1_COLOR, 16'h7FFE);
        write_reg(CFG_TRACE2_COLOR, 16'hFFFF);
        for (int b = 0; b < NB; b++)
        begin
            pending_items.push_back(load_item(1'b0, 8'(b), random_mag()));
            pending_items.push_back(load_item(1'b1, 8'(b), random_mag()));
        end
        hold_off_cycles = 3000;
        queue_phase(100);
        wait_drained();

        send_idle_pct = 46;
        recv_idle_pct = 12;
        write_reg(CFG_X_ZOOM_RECIP, 16'd128);
        write_reg(CFG_X_PAN, 16'h07C0);
        write_reg(CFG_Y_ZOOM, 16'd512);
        write_reg(CFG_Y_PAN, 16'h03E0);
        queue_phase(100);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_X_ZOOM_RECIP, 16'd600);
        write_reg(CFG_X_PAN, 16'h0100);
        write_reg(CFG_Y_ZOOM, 16'd200);
        write_reg(CFG_Y_PAN, 16'h0040);
        queue_phase(100);
        wait_drained();

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
